@@ sv/cfc_pkg.sv @@
package cfc_pkg;

    localparam int FRAME_BYTES_DEF = 68;
    localparam int POS_W           = 8;
    localparam int BYTE_W          = 8;
    localparam int CFG_IDX_W       = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXP_HEADER = 1'd0,
        CFG_EXP_FOOTER = 1'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ROLE_HEADER  = 3'd0,
        ROLE_PAYLOAD = 3'd1,
        ROLE_CHECK_A = 3'd2,
        ROLE_CHECK_B = 3'd3,
        ROLE_FOOTER  = 3'd4,
        ROLE_OUTSIDE = 3'd5
    } t_role;

    typedef enum logic [1:0] {
        STAT_GOOD       = 2'd0,
        STAT_BAD_HEADER = 2'd1,
        STAT_BAD_FOOTER = 2'd2,
        STAT_BAD_CHECK  = 2'd3
    } t_status;

    // Control from the pipeline to the frame tracker
    typedef struct packed {
        logic advance;
        logic start;
    } t_track_ctl;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_echo;
        t_role             byte_role;
        logic              frame_end;
        t_status           frame_status;
    } t_result;

endpackage

@@ sv/checksummed_frame_checker_top.sv @@
// A result item is presented from the result register once its input item has
// been accepted into the input register and moved on from there.
// Throughput: 1 item per cycle while i_stall is low; the input and result
// registers form a two-stage pipeline and the frame state updates once per byte.
// Reset (i_rst_n low, synchronous): both stages empty, frame position, sums,
// match flags and the expected header/footer registers cleared to zero.
module checksummed_frame_checker_top
    import cfc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_frame_start,
    // result item channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [BYTE_W-1:0]    o_byte_echo,
    output logic [2:0]           o_byte_role,
    output logic                 o_frame_end,
    output logic [1:0]           o_frame_status,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    // Configuration registers
    logic [BYTE_W-1:0] r_exp_header;
    logic [BYTE_W-1:0] r_exp_footer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_header <= '0;
            r_exp_footer <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_EXP_HEADER: r_exp_header <= i_cfg_data;
                CFG_EXP_FOOTER: r_exp_footer <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control: the result register can load when empty or when its
    // item is being taken; the input register moves its item on in that case.
    logic r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic r_in_start;
    logic r_out_valid;
    t_result r_out;
    t_result w_result;
    logic w_out_open;
    logic w_move;
    t_track_ctl w_ctl;

    assign w_out_open = !r_out_valid || !i_stall;
    assign w_move     = r_in_valid && w_out_open;
    assign o_stall    = r_in_valid && !w_out_open;

    // Input register: take a new item whenever the held one leaves or none is held
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte  <= i_rx_byte;
            r_in_start <= i_frame_start;
        end
    end

    // Frame state and verdict logic; state advances only when the item moves on
    assign w_ctl.advance = w_move;
    assign w_ctl.start   = r_in_start;

    cfc_frame_track #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_byte       (r_in_byte),
        .i_exp_header (r_exp_header),
        .i_exp_footer (r_exp_footer),
        .o_result     (w_result)
    );

    // Result register: hold while stalled, load the computed item on a move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_open) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_byte_echo    = r_out.byte_echo;
    assign o_byte_role    = r_out.byte_role;
    assign o_frame_end    = r_out.frame_end;
    assign o_frame_status = r_out.frame_status;

    // A verdict only appears on the footer byte
    a_end_is_footer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> (r_out.byte_role == ROLE_FOOTER))
        else $error("frame_end on a byte that is not the footer");

    // A nonzero status only comes with frame_end
    a_status_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.frame_status != STAT_GOOD)) |-> r_out.frame_end)
        else $error("frame_status set without frame_end");

    // An item moved out of the input register shows up as a result next cycle
    a_move_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> r_out_valid)
        else $error("item lost between input and result registers");

    // A held result stays put while stalled
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result item changed");

endmodule

@@ sv/cfc_frame_track.sv @@
module cfc_frame_track
    import cfc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_track_ctl        i_ctl,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_exp_header,
    input  logic [BYTE_W-1:0] i_exp_footer,
    output t_result           o_result
);

    localparam logic [POS_W-1:0] LAST_POS     = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_PAYLOAD = POS_W'(FRAME_BYTES - 4);
    localparam logic [POS_W-1:0] CHECK_A_POS  = POS_W'(FRAME_BYTES - 3);
    localparam logic [POS_W-1:0] CHECK_B_POS  = POS_W'(FRAME_BYTES - 2);

    logic [POS_W-1:0]  r_pos, n_pos, w_pos;
    logic [BYTE_W-1:0] r_sum, n_sum, w_sum;
    logic [BYTE_W-1:0] r_sos, n_sos, w_sos;
    logic              r_hdr_ok, n_hdr_ok, w_hdr_ok;
    logic              r_chk_a_ok, n_chk_a_ok, w_chk_a_ok;
    logic              r_chk_b_ok, n_chk_b_ok, w_chk_b_ok;

    always_comb begin
        // start restarts position, sums and match bits
        w_pos      = i_ctl.start ? '0 : r_pos;
        w_sum      = i_ctl.start ? '0 : r_sum;
        w_sos      = i_ctl.start ? '0 : r_sos;
        w_hdr_ok   = i_ctl.start ? 1'b0 : r_hdr_ok;
        w_chk_a_ok = i_ctl.start ? 1'b0 : r_chk_a_ok;
        w_chk_b_ok = i_ctl.start ? 1'b0 : r_chk_b_ok;

        n_pos      = w_pos;
        n_sum      = w_sum;
        n_sos      = w_sos;
        n_hdr_ok   = w_hdr_ok;
        n_chk_a_ok = w_chk_a_ok;
        n_chk_b_ok = w_chk_b_ok;

        o_result.byte_echo    = i_byte;
        o_result.byte_role    = ROLE_OUTSIDE;
        o_result.frame_end    = 1'b0;
        o_result.frame_status = STAT_GOOD;

        if (w_pos >= LAST_POS) begin
            o_result.byte_role = ROLE_OUTSIDE;
        end else if (w_pos == '0) begin
            o_result.byte_role = ROLE_HEADER;
            n_sum    = '0;
            n_sos    = '0;
            n_hdr_ok = (i_byte == i_exp_header);
        end else if (w_pos <= LAST_PAYLOAD) begin
            o_result.byte_role = ROLE_PAYLOAD;
            n_sum = w_sum + i_byte;
            n_sos = w_sos + n_sum;
        end else if (w_pos == CHECK_A_POS) begin
            o_result.byte_role = ROLE_CHECK_A;
            n_chk_a_ok = (i_byte == w_sum);
        end else if (w_pos == CHECK_B_POS) begin
            o_result.byte_role = ROLE_CHECK_B;
            n_chk_b_ok = (i_byte == w_sos);
        end else begin
            o_result.byte_role = ROLE_FOOTER;
            o_result.frame_end = 1'b1;
            if (!w_hdr_ok) begin
                o_result.frame_status = STAT_BAD_HEADER;
            end else if (i_byte != i_exp_footer) begin
                o_result.frame_status = STAT_BAD_FOOTER;
            end else if (!(w_chk_a_ok && w_chk_b_ok)) begin
                o_result.frame_status = STAT_BAD_CHECK;
            end
        end

        // saturate at the frame end
        if (w_pos < LAST_POS) begin
            n_pos = w_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_sum      <= '0;
            r_sos      <= '0;
            r_hdr_ok   <= 1'b0;
            r_chk_a_ok <= 1'b0;
            r_chk_b_ok <= 1'b0;
        end else if (i_ctl.advance) begin
            r_pos      <= n_pos;
            r_sum      <= n_sum;
            r_sos      <= n_sos;
            r_hdr_ok   <= n_hdr_ok;
            r_chk_a_ok <= n_chk_a_ok;
            r_chk_b_ok <= n_chk_b_ok;
        end
    end

endmodule

@@ tb/checksummed_frame_checker_top_tb.sv @@
`timescale 1ns / 100ps

module checksummed_frame_checker_top_tb;
    import cfc_pkg::*;

    localparam int FRAME_BYTES     = FRAME_BYTES_DEF;
    localparam int HALF_PERIOD     = 10;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 3;

    // Shapes of frame the traffic generator can build
    typedef enum int {
        FR_GOOD        = 0,
        FR_BAD_HEADER  = 1,
        FR_BAD_FOOTER  = 2,
        FR_BAD_CHECK_A = 3,
        FR_BAD_CHECK_B = 4,
        FR_BAD_ALL     = 5,
        FR_CUT_SHORT   = 6
    } t_frame_kind;

    // Payload content patterns
    typedef enum int {
        FILL_RANDOM = 0,
        FILL_ZERO   = 1,
        FILL_ONES   = 2
    } t_fill;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [BYTE_W-1:0]    i_rx_byte;
    logic                 i_frame_start;
    logic                 o_valid;
    logic                 i_stall;
    logic [BYTE_W-1:0]    o_byte_echo;
    logic [2:0]           o_byte_role;
    logic                 o_frame_end;
    logic [1:0]           o_frame_status;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [BYTE_W-1:0]    i_cfg_data;

    // Frame tracker mirror: registers and per-frame state
    logic [7:0] want_header;
    logic [7:0] want_footer;
    logic [7:0] frame_pos;
    logic [7:0] run_sum;
    logic [7:0] sum_of_runs;
    logic       header_ok;
    logic       check_a_ok;
    logic       check_b_ok;

    t_result pending_results[$];

    int mismatches;
    int sent_items;
    int send_idle_pct;
    int stall_pct;
    int quiet_cycles;

    checksummed_frame_checker_top #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_byte_echo   (o_byte_echo),
        .o_byte_role   (o_byte_role),
        .o_frame_end   (o_frame_end),
        .o_frame_status(o_frame_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Work out the result of one accepted byte and advance the tracker mirror.
    function automatic t_result classify_byte(logic [7:0] rx, logic start);
        t_result r;
        if (start) begin
            frame_pos   = '0;
            run_sum     = '0;
            sum_of_runs = '0;
            header_ok   = 1'b0;
            check_a_ok  = 1'b0;
            check_b_ok  = 1'b0;
        end
        r.byte_echo    = rx;
        r.frame_end    = 1'b0;
        r.frame_status = STAT_GOOD;
        if (frame_pos >= FRAME_BYTES) begin
            r.byte_role = ROLE_OUTSIDE;
        end else if (frame_pos == 0) begin
            r.byte_role = ROLE_HEADER;
            run_sum     = '0;
            sum_of_runs = '0;
            header_ok   = (rx == want_header);
        end else if (frame_pos <= FRAME_BYTES - 4) begin
            r.byte_role = ROLE_PAYLOAD;
            run_sum     = run_sum + rx;
            sum_of_runs = sum_of_runs + run_sum;
        end else if (frame_pos == FRAME_BYTES - 3) begin
            r.byte_role = ROLE_CHECK_A;
            check_a_ok  = (rx == run_sum);
        end else if (frame_pos == FRAME_BYTES - 2) begin
            r.byte_role = ROLE_CHECK_B;
            check_b_ok  = (rx == sum_of_runs);
        end else begin
            // Footer: verdict priority is header, then footer, then checksum
            r.byte_role = ROLE_FOOTER;
            r.frame_end = 1'b1;
            if (!header_ok)
                r.frame_status = STAT_BAD_HEADER;
            else if (rx != want_footer)
                r.frame_status = STAT_BAD_FOOTER;
            else if (!(check_a_ok && check_b_ok))
                r.frame_status = STAT_BAD_CHECK;
        end
        // Saturate at the frame end so trailing bytes stay outside
        if (frame_pos < FRAME_BYTES)
            frame_pos = frame_pos + 8'd1;
        return r;
    endfunction

    function automatic void note_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    endfunction

    // Offer one item, idling first at random, and hold it until accepted.
    task automatic send_byte(input logic [7:0] rx, input logic start);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid       <= 1'b0;
            i_rx_byte     <= 8'($urandom);
            i_frame_start <= 1'($urandom);
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct)
                @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= rx;
        i_frame_start <= start;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending_results.push_back(classify_byte(rx, start));
        sent_items++;
    endtask

    // Drop valid and hold off until every expected result is back.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both match registers; only call while the block is drained.
    task automatic set_match_bytes(input logic [7:0] header, input logic [7:0] footer);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_EXP_HEADER;
        i_cfg_data  <= header;
        @(posedge i_clk);
        i_cfg_index <= CFG_EXP_FOOTER;
        i_cfg_data  <= footer;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        want_header = header;
        want_footer = footer;
    endtask

    // Build one frame against the current match bytes, then trailing bytes.
    task automatic send_frame(input t_frame_kind kind, input t_fill fill, input int trailing);
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        logic [7:0] rx;
        int         stop_at;
        sum_a   = '0;
        sum_b   = '0;
        stop_at = (kind == FR_CUT_SHORT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
        for (int p = 0; p < stop_at; p++) begin
            if (p == 0) begin
                rx = want_header;
                if (kind == FR_BAD_HEADER || kind == FR_BAD_ALL)
                    rx = rx ^ 8'($urandom_range(1, 255));
            end else if (p <= FRAME_BYTES - 4) begin
                case (fill)
                    FILL_ZERO: rx = 8'h00;
                    FILL_ONES: rx = 8'hFF;
                    default:   rx = 8'($urandom);
                endcase
                sum_a = sum_a + rx;
                sum_b = sum_b + sum_a;
            end else if (p == FRAME_BYTES - 3) begin
                rx = sum_a;
                if (kind == FR_BAD_CHECK_A || kind == FR_BAD_ALL)
                    rx = rx ^ 8'($urandom_range(1, 255));
            end else if (p == FRAME_BYTES - 2) begin
                rx = sum_b;
                if (kind == FR_BAD_CHECK_B || kind == FR_BAD_ALL)
                    rx = rx ^ 8'($urandom_range(1, 255));
            end else begin
                rx = want_footer;
                if (kind == FR_BAD_FOOTER || kind == FR_BAD_ALL)
                    rx = rx ^ 8'($urandom_range(1, 255));
            end
            send_byte(rx, p == 0);
        end
        for (int t = 0; t < trailing; t++)
            send_byte(8'($urandom), 1'b0);
    endtask

    // Mixed traffic: well-formed frames (payloads mostly random), about as many
    // corrupted or cut short, and some bursts of raw noise.
    task automatic run_frames(input int idle_pct, input int stall_pct_set,
                              input logic [7:0] header, input logic [7:0] footer,
                              input bit pause_midway);
        int          phase_start;
        int          pick;
        bit          paused;
        t_frame_kind kind;
        t_fill       fill;
        wait_results_drained();
        send_idle_pct = idle_pct;
        stall_pct     = stall_pct_set;
        set_match_bytes(header, footer);
        phase_start = sent_items;
        paused      = 1'b0;
        while (sent_items - phase_start < ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 20))
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end else begin
                kind = (pick < 55) ? FR_GOOD : t_frame_kind'($urandom_range(1, 6));
                pick = $urandom_range(0, 9);
                fill = (pick == 0) ? FILL_ZERO : (pick == 1) ? FILL_ONES : FILL_RANDOM;
                send_frame(kind, fill, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            end
            // Let the pipeline run dry once in the middle of the phase
            if (pause_midway && !paused && sent_items - phase_start >= ITEMS_PER_PHASE / 2) begin
                wait_results_drained();
                paused = 1'b1;
            end
        end
    endtask

    // Short corner cases at reset values, then at the register extremes.
    task automatic test_directed_cases();
        // No start after reset: the first byte still counts as the header
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        // Start in mid-frame drops the frame in progress
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b0);
        // Back-to-back starts keep every byte a header
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h7F, 1'b1);
        wait_results_drained();
        set_match_bytes(8'hFF, 8'h00);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFE, 1'b1);
        send_byte(8'h00, 1'b0);
        wait_results_drained();
        set_match_bytes(8'h00, 8'hFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
    endtask

    // A full good frame followed by enough trailing bytes that a position
    // counter without saturation would wrap back into the frame.
    task automatic test_saturation_past_end();
        wait_results_drained();
        set_match_bytes(8'hA5, 8'h5A);
        send_frame(FR_GOOD, FILL_RANDOM, 200);
    endtask

    task automatic test_frames_no_idling();
        run_frames(0, 0, 8'h00, 8'h00, 1'b0);
    endtask

    task automatic test_frames_sender_idle();
        run_frames(61, 0, 8'hFF, 8'hFF, 1'b1);
    endtask

    task automatic test_frames_receiver_stall();
        run_frames(0, 61, 8'($urandom), 8'($urandom), 1'b0);
    endtask

    task automatic test_frames_both_idle();
        run_frames(22, 22, 8'h00, 8'hFF, 1'b0);
    endtask

    // Receiver side: stall at random by the current percentage.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with nothing pending, echo", -1, o_byte_echo);
            end else begin
                want = pending_results.pop_front();
                if (o_byte_echo !== want.byte_echo)
                    note_mismatch("byte_echo", want.byte_echo, o_byte_echo);
                if (o_byte_role !== want.byte_role)
                    note_mismatch("byte_role", want.byte_role, o_byte_role);
                if (o_frame_end !== want.frame_end)
                    note_mismatch("frame_end", want.frame_end, o_frame_end);
                if (o_frame_status !== want.frame_status)
                    note_mismatch("frame_status", want.frame_status, o_frame_status);
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_rx_byte     = '0;
        i_frame_start = 1'b0;
        i_stall       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_EXP_HEADER;
        i_cfg_data    = '0;
        want_header   = '0;
        want_footer   = '0;
        frame_pos     = '0;
        run_sum       = '0;
        sum_of_runs   = '0;
        header_ok     = 1'b0;
        check_a_ok    = 1'b0;
        check_b_ok    = 1'b0;
        mismatches    = 0;
        sent_items    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_saturation_past_end();
        test_frames_no_idling();
        test_frames_sender_idle();
        test_frames_receiver_stall();
        test_frames_both_idle();

        wait_results_drained();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
